[sv/ketr_pkg.sv]
// ----------------------------------------------------------------------------
// ketr_pkg
// Shared types, codes and helpers for the typematic key repeat block.
// ----------------------------------------------------------------------------
package ketr_pkg;

    // event kinds carried in a result beat
    localparam logic [2:0] KIND_PRESS    = 3'd0;
    localparam logic [2:0] KIND_RELEASE  = 3'd1;
    localparam logic [2:0] KIND_REPEAT   = 3'd2;
    localparam logic [2:0] KIND_MODIFIER = 3'd3;
    localparam logic [2:0] KIND_RAW      = 3'd4;

    // input operations
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // key values from the device
    localparam logic [1:0] VAL_RELEASE = 2'd0;
    localparam logic [1:0] VAL_PRESS   = 2'd1;

    // keys that accelerate while repeating
    localparam logic [9:0] CODE_BACKSPACE = 10'd14;
    localparam logic [9:0] CODE_DELETE    = 10'd111;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_START   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_FLOOR   = 3'd4;

    // reset values of the configuration registers
    localparam logic [15:0] RST_INITIAL_DELAY = 16'd500;
    localparam logic [15:0] RST_REPEAT_DELAY  = 16'd60;
    localparam logic [15:0] RST_ACCEL_START   = 16'd50;
    localparam logic [7:0]  RST_ACCEL_STEP    = 8'd5;
    localparam logic [15:0] RST_ACCEL_FLOOR   = 16'd10;

    localparam logic [3:0]  COUNT_MAX   = 4'd15;
    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

    typedef struct packed {
        logic       operation;
        logic [9:0] key_code;
        logic [1:0] key_value;
    } t_in;

    typedef struct packed {
        logic [2:0] event_kind;
        logic [9:0] code_out;
        logic       active;
        logic [1:0] raw_value;
        logic [3:0] modifier_mask;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [15:0] initial_delay_ms;
        logic [15:0] repeat_delay_ms;
        logic [15:0] accel_start_ms;
        logic [7:0]  accel_step_ms;
        logic [15:0] accel_floor_ms;
    } t_cfg;

    // push request from the core into the result queue
    typedef struct packed {
        logic [1:0] count;
        t_out       res0;
        t_out       res1;
    } t_push;

    // modifier mask bit of a key code, zero for ordinary keys
    function automatic logic [3:0] modifier_of(input logic [9:0] code);
        logic [3:0] m;
        unique case (code)
            10'd42, 10'd54:   m = 4'b0001;
            10'd29, 10'd97:   m = 4'b0010;
            10'd56, 10'd100:  m = 4'b0100;
            10'd125, 10'd126: m = 4'b1000;
            default:          m = 4'b0000;
        endcase
        return m;
    endfunction

endpackage

[sv/ketr_cfg.sv]
// ----------------------------------------------------------------------------
// ketr_cfg
// Configuration register bank; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module ketr_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [ketr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    output logic                          o_cfg_ready,
    output ketr_pkg::t_cfg                o_cfg
);

    ketr_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_delay_ms <= ketr_pkg::RST_INITIAL_DELAY;
            r_cfg.repeat_delay_ms  <= ketr_pkg::RST_REPEAT_DELAY;
            r_cfg.accel_start_ms   <= ketr_pkg::RST_ACCEL_START;
            r_cfg.accel_step_ms    <= ketr_pkg::RST_ACCEL_STEP;
            r_cfg.accel_floor_ms   <= ketr_pkg::RST_ACCEL_FLOOR;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ketr_pkg::CFG_INITIAL_DELAY: r_cfg.initial_delay_ms <= i_cfg_data;
                ketr_pkg::CFG_REPEAT_DELAY:  r_cfg.repeat_delay_ms  <= i_cfg_data;
                ketr_pkg::CFG_ACCEL_START:   r_cfg.accel_start_ms   <= i_cfg_data;
                ketr_pkg::CFG_ACCEL_STEP:    r_cfg.accel_step_ms    <= i_cfg_data[7:0];
                ketr_pkg::CFG_ACCEL_FLOOR:   r_cfg.accel_floor_ms   <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

[sv/ketr_core.sv]
// ----------------------------------------------------------------------------
// ketr_core
// Input register, repeat and modifier state, and result generation.
// ----------------------------------------------------------------------------
module ketr_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  ketr_pkg::t_in  i_in_data,
    output logic           o_in_stall,
    input  ketr_pkg::t_cfg i_cfg,
    input  logic           i_room,
    output ketr_pkg::t_push o_push
);

    logic          r_in_valid;
    ketr_pkg::t_in r_in;

    logic        r_armed,   n_armed;
    logic [9:0]  r_key,     n_key;
    logic [3:0]  r_count,   n_count;
    logic [15:0] r_elapsed, n_elapsed;
    logic [15:0] r_delay,   n_delay;
    logic [3:0]  r_mods,    n_mods;

    logic        fire;
    logic        accept;
    logic [15:0] el_inc;
    logic [15:0] limit;
    logic [3:0]  cnt_inc;
    logic [11:0] cut;
    logic [15:0] diff;
    logic [3:0]  mbit;

    assign fire       = r_in_valid & i_room;
    assign o_in_stall = r_in_valid & ~i_room;
    assign accept     = i_in_valid & ~o_in_stall;

    // hold one input beat until the queue has room for its results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
    end

    // tick arithmetic
    assign el_inc  = (r_elapsed == ketr_pkg::ELAPSED_MAX) ? r_elapsed : r_elapsed + 16'd1;
    assign limit   = (r_count == 4'd0) ? i_cfg.initial_delay_ms : r_delay;
    assign cnt_inc = (r_count == ketr_pkg::COUNT_MAX) ? r_count : r_count + 4'd1;
    assign cut     = 12'(cnt_inc) * 12'(i_cfg.accel_step_ms);
    assign diff    = ({4'b0, cut} >= i_cfg.accel_start_ms) ? 16'd0
                   : i_cfg.accel_start_ms - {4'b0, cut};
    assign mbit    = ketr_pkg::modifier_of(r_in.key_code);

    // next state and results of the registered beat
    always_comb begin
        n_armed   = r_armed;
        n_key     = r_key;
        n_count   = r_count;
        n_elapsed = r_elapsed;
        n_delay   = r_delay;
        n_mods    = r_mods;
        o_push    = '0;
        if (fire) begin
            if (r_in.operation == ketr_pkg::OP_TICK) begin
                if (r_armed) begin
                    if (el_inc >= limit) begin
                        n_elapsed = 16'd0;
                        n_count   = cnt_inc;
                        if (r_key == ketr_pkg::CODE_BACKSPACE ||
                            r_key == ketr_pkg::CODE_DELETE) begin
                            n_delay = (diff > i_cfg.accel_floor_ms) ? diff
                                    : i_cfg.accel_floor_ms;
                        end
                        o_push.count              = 2'd1;
                        o_push.res0.event_kind    = ketr_pkg::KIND_REPEAT;
                        o_push.res0.code_out      = r_key;
                        o_push.res0.active        = 1'b1;
                        o_push.res0.modifier_mask = r_mods;
                        o_push.res0.last          = 1'b1;
                    end else begin
                        n_elapsed = el_inc;
                    end
                end
            end else begin
                // release of the armed key disarms, modifiers included
                if (r_in.key_value == ketr_pkg::VAL_RELEASE && r_armed &&
                    r_key == r_in.key_code) begin
                    n_armed = 1'b0;
                    n_count = 4'd0;
                end
                if (mbit != 4'd0) begin
                    n_mods = (r_in.key_value != ketr_pkg::VAL_RELEASE) ? (r_mods | mbit)
                           : (r_mods & ~mbit);
                    o_push.count              = 2'd2;
                    o_push.res0.event_kind    = ketr_pkg::KIND_MODIFIER;
                    o_push.res0.code_out      = r_in.key_code;
                    o_push.res0.active        = (r_in.key_value != ketr_pkg::VAL_RELEASE);
                    o_push.res0.modifier_mask = n_mods;
                    o_push.res1.event_kind    = ketr_pkg::KIND_RAW;
                    o_push.res1.code_out      = r_in.key_code;
                    o_push.res1.raw_value     = r_in.key_value;
                    o_push.res1.modifier_mask = n_mods;
                    o_push.res1.last          = 1'b1;
                end else if (r_in.key_value == ketr_pkg::VAL_PRESS) begin
                    n_armed   = 1'b1;
                    n_key     = r_in.key_code;
                    n_count   = 4'd0;
                    n_elapsed = 16'd0;
                    n_delay   = i_cfg.repeat_delay_ms;
                    o_push.count              = 2'd1;
                    o_push.res0.event_kind    = ketr_pkg::KIND_PRESS;
                    o_push.res0.code_out      = r_in.key_code;
                    o_push.res0.active        = 1'b1;
                    o_push.res0.modifier_mask = r_mods;
                    o_push.res0.last          = 1'b1;
                end else if (r_in.key_value == ketr_pkg::VAL_RELEASE) begin
                    o_push.count              = 2'd1;
                    o_push.res0.event_kind    = ketr_pkg::KIND_RELEASE;
                    o_push.res0.code_out      = r_in.key_code;
                    o_push.res0.modifier_mask = r_mods;
                    o_push.res0.last          = 1'b1;
                end
            end
        end
    end

    // advance the repeat and modifier state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed   <= 1'b0;
            r_key     <= 10'd0;
            r_count   <= 4'd0;
            r_elapsed <= 16'd0;
            r_delay   <= ketr_pkg::RST_REPEAT_DELAY;
            r_mods    <= 4'd0;
        end else begin
            r_armed   <= n_armed;
            r_key     <= n_key;
            r_count   <= n_count;
            r_elapsed <= n_elapsed;
            r_delay   <= n_delay;
            r_mods    <= n_mods;
        end
    end

endmodule

[sv/ketr_outq.sv]
// ----------------------------------------------------------------------------
// ketr_outq
// Four-entry result queue: takes up to two results a cycle, gives one unless stalled.
// ----------------------------------------------------------------------------
module ketr_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ketr_pkg::t_push i_push,
    output logic            o_room,
    output logic            o_out_valid,
    output ketr_pkg::t_out  o_out_data,
    input  logic            i_out_stall
);

    ketr_pkg::t_out r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt, n_cnt;
    logic       pop;
    logic [1:0] wp1;

    assign o_room      = (r_cnt < 3'd3);
    assign o_out_valid = (r_cnt != 3'd0);
    assign o_out_data  = r_mem[r_rp];
    assign pop         = o_out_valid & ~i_out_stall;
    assign wp1         = r_wp + 2'd1;
    assign n_cnt       = r_cnt + {1'b0, i_push.count} - {2'b0, pop};

    // store pushed results
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wp1] <= i_push.res1;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp  <= r_wp + i_push.count;
            r_rp  <= r_rp + {1'b0, pop};
            r_cnt <= n_cnt;
        end
    end

endmodule

[sv/key_event_typematic_repeat.sv]
// ----------------------------------------------------------------------------
// key_event_typematic_repeat
// Typematic auto-repeat engine with modifier tracking.
// ----------------------------------------------------------------------------
// One input beat is accepted per cycle unless stalled; its results are queued
// once the queue has room. Ordinary key events and ticks give at most one
// result and, unless the output stalls, sustain one item per cycle; a
// modifier event gives two results and the single-beat queue output sets the
// pace. Configuration writes are always ready and take effect the next cycle.
module key_event_typematic_repeat (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  ketr_pkg::t_in                  i_in_data,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    output ketr_pkg::t_out                 o_out_data,
    input  logic                           i_out_stall,
    input  logic                           i_cfg_valid,
    input  logic [ketr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data,
    output logic                           o_cfg_ready
);

    ketr_pkg::t_cfg  cfg;
    ketr_pkg::t_push push;
    logic            room;

    ketr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    ketr_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_cfg      (cfg),
        .i_room     (room),
        .o_push     (push)
    );

    ketr_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

[sv/ketr_checker.sv]
// ----------------------------------------------------------------------------
// ketr_checker
// Port-level checks of the typematic repeat block, bound to the top level.
// ----------------------------------------------------------------------------
module ketr_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input ketr_pkg::t_out o_out_data,
    input logic           i_out_stall
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

    // a taken modifier beat is followed at once by its raw-key beat
    a_mod_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall &&
        o_out_data.event_kind == ketr_pkg::KIND_MODIFIER
        |=> o_out_valid && o_out_data.event_kind == ketr_pkg::KIND_RAW &&
            o_out_data.code_out == $past(o_out_data.code_out))
        else $error("modifier beat not followed by raw-key beat");

    // only the final beat of an input is marked last
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last == (o_out_data.event_kind != ketr_pkg::KIND_MODIFIER)))
        else $error("last flag wrong for event kind");

    // press and repeat beats are active with a zero raw value
    a_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.event_kind == ketr_pkg::KIND_PRESS ||
                        o_out_data.event_kind == ketr_pkg::KIND_REPEAT)
        |-> o_out_data.active && o_out_data.raw_value == 2'd0)
        else $error("press or repeat beat not active");

endmodule

bind key_event_typematic_repeat ketr_checker u_ketr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

[verif/key_event_typematic_repeat_test.sv]
// ----------------------------------------------------------------------------
// key_event_typematic_repeat_test
// Self-checking bench for the typematic key repeat engine. A clocked driver
// feeds key and tick beats from a pending queue, a clocked monitor checks
// every result beat against a scoreboard filled by a cycle-free predictor.
// Directed beats cover the modifier keys, odd key values and the default
// timing; random typing sequences then run under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_event_typematic_repeat_test;
    import ketr_pkg::*;

    localparam int RUN_LIMIT  = 1500000;
    localparam int SETTLE     = 8;
    localparam int PRINT_MAX  = 40;

    // modifier key codes
    localparam logic [9:0] KEY_LSHIFT = 10'd42;
    localparam logic [9:0] KEY_RSHIFT = 10'd54;
    localparam logic [9:0] KEY_LCTRL  = 10'd29;
    localparam logic [9:0] KEY_RCTRL  = 10'd97;
    localparam logic [9:0] KEY_LALT   = 10'd56;
    localparam logic [9:0] KEY_RALT   = 10'd100;
    localparam logic [9:0] KEY_LMETA  = 10'd125;
    localparam logic [9:0] KEY_RMETA  = 10'd126;
    localparam logic [9:0] KEY_TOP    = 10'd767;

    // device values beyond release and press
    localparam logic [1:0] VAL_DEVICE_REPEAT = 2'd2;
    localparam logic [1:0] VAL_UNUSED        = 2'd3;

    typedef struct {
        logic [CFG_IDX_W-1:0] index;
        logic [15:0]          data;
    } t_reg_write;

    logic i_clk;
    logic rst_n = 1'b0;

    logic       in_valid = 1'b0;
    t_in        in_beat  = '0;
    logic       in_stall;
    logic       out_valid;
    t_out       out_beat;
    logic       out_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic       cfg_ready;

    key_event_typematic_repeat dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_beat),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_beat),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (cfg_ready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state and register shadow
    // ------------------------------------------------------------------
    int          initial_ms = int'(RST_INITIAL_DELAY);
    int          repeat_ms  = int'(RST_REPEAT_DELAY);
    int          accel_ms   = int'(RST_ACCEL_START);
    int          cut_ms     = int'(RST_ACCEL_STEP);
    int          floor_ms   = int'(RST_ACCEL_FLOOR);

    logic        armed      = 1'b0;
    logic [9:0]  armed_key  = '0;
    int          repeats    = 0;
    int          held_ticks = 0;
    int          gap_ms     = int'(RST_REPEAT_DELAY);
    logic [3:0]  mods_down  = '0;

    t_out        awaited_events[$];
    t_in         pending_beats[$];
    t_reg_write  pending_regs[$];

    int beats_queued = 0;
    int beats_taken  = 0;
    int regs_queued  = 0;
    int regs_written = 0;
    int events_seen  = 0;
    int mismatches   = 0;
    int send_gap     = 0;
    int stall_left   = 0;
    logic calm       = 1'b0;
    t_reg_write next_reg;

    function automatic logic [3:0] mask_for_key(input logic [9:0] code);
        if (code == KEY_LSHIFT || code == KEY_RSHIFT) return 4'b0001;
        if (code == KEY_LCTRL  || code == KEY_RCTRL)  return 4'b0010;
        if (code == KEY_LALT   || code == KEY_RALT)   return 4'b0100;
        if (code == KEY_LMETA  || code == KEY_RMETA)  return 4'b1000;
        return 4'b0000;
    endfunction

    task automatic add_event(input logic [2:0] kind, input logic [9:0] code,
                             input logic act, input logic [1:0] raw,
                             input logic lst);
        t_out r;
        r.event_kind    = kind;
        r.code_out      = code;
        r.active        = act;
        r.raw_value     = raw;
        r.modifier_mask = mods_down;
        r.last          = lst;
        awaited_events = {awaited_events, r};
    endtask

    // Advance the typematic state by one accepted beat, queue its results
    task automatic advance_typematic(input t_in b);
        int          limit;
        int          cut;
        int          d;
        logic [3:0]  mbit;
        if (b.operation == OP_TICK) begin
            if (!armed) return;
            if (held_ticks < 65535) held_ticks++;
            limit = (repeats == 0) ? initial_ms : gap_ms;
            if (held_ticks < limit) return;
            add_event(KIND_REPEAT, armed_key, 1'b1, 2'd0, 1'b1);
            if (repeats < 15) repeats++;
            held_ticks = 0;
            // backspace and delete shorten their delay down to the floor
            if (armed_key == CODE_BACKSPACE || armed_key == CODE_DELETE) begin
                cut    = repeats * cut_ms;
                d      = (cut >= accel_ms) ? 0 : accel_ms - cut;
                gap_ms = (d > floor_ms) ? d : floor_ms;
            end
            return;
        end
        // release of the armed key disarms, modifier or not
        if (b.key_value == VAL_RELEASE && armed && armed_key == b.key_code) begin
            armed   = 1'b0;
            repeats = 0;
        end
        mbit = mask_for_key(b.key_code);
        if (mbit != 4'b0000) begin
            if (b.key_value != VAL_RELEASE) mods_down = mods_down | mbit;
            else                            mods_down = mods_down & ~mbit;
            add_event(KIND_MODIFIER, b.key_code, b.key_value != VAL_RELEASE,
                      2'd0, 1'b0);
            add_event(KIND_RAW, b.key_code, 1'b0, b.key_value, 1'b1);
            return;
        end
        if (b.key_value == VAL_PRESS) begin
            armed      = 1'b1;
            armed_key  = b.key_code;
            repeats    = 0;
            held_ticks = 0;
            gap_ms     = repeat_ms;
            add_event(KIND_PRESS, b.key_code, 1'b1, 2'd0, 1'b1);
        end else if (b.key_value == VAL_RELEASE) begin
            add_event(KIND_RELEASE, b.key_code, 1'b0, 2'd0, 1'b1);
        end
    endtask

    task automatic shadow_register(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [15:0] data);
        case (idx)
            CFG_INITIAL_DELAY: initial_ms = int'(data);
            CFG_REPEAT_DELAY:  repeat_ms  = int'(data);
            CFG_ACCEL_START:   accel_ms   = int'(data);
            CFG_ACCEL_STEP:    cut_ms     = int'(data[7:0]);
            CFG_ACCEL_FLOOR:   floor_ms   = int'(data);
            default: ;
        endcase
    endtask

    // Mostly no pause, some short ones, a few long ones; none in calm stretches
    function automatic int draw_pause();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatches < PRINT_MAX)
            $display("[%0t] result %0d %s: got %0h, expected %0h",
                     $time, events_seen, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Driver: input beats and register writes
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                advance_typematic(in_beat);
                beats_taken++;
                if (beats_taken % 100 == 0) calm = ($urandom_range(0, 3) == 0);
            end
            // hold a stalled beat, otherwise pause or present the next one
            if (in_valid && in_stall) begin
            end else if (send_gap != 0) begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_beats.size() != 0) begin
                in_beat  <= pending_beats.pop_front();
                in_valid <= 1'b1;
                send_gap <= draw_pause();
            end else begin
                in_valid <= 1'b0;
            end

            if (cfg_valid && cfg_ready) begin
                shadow_register(cfg_index, cfg_data);
                regs_written++;
            end
            if (cfg_valid && !cfg_ready) begin
            end else if (pending_regs.size() != 0) begin
                next_reg   = pending_regs.pop_front();
                cfg_valid <= 1'b1;
                cfg_index <= next_reg.index;
                cfg_data  <= next_reg.data;
            end else begin
                cfg_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check result beats, stall at random
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (awaited_events.size() == 0) begin
                    report_mismatch("unexpected, kind", 16'(out_beat.event_kind), 16'h0);
                end else begin
                    want = awaited_events.pop_front();
                    if (out_beat.event_kind !== want.event_kind)
                        report_mismatch("event_kind", 16'(out_beat.event_kind),
                                        16'(want.event_kind));
                    if (out_beat.code_out !== want.code_out)
                        report_mismatch("code_out", 16'(out_beat.code_out),
                                        16'(want.code_out));
                    if (out_beat.active !== want.active)
                        report_mismatch("active", 16'(out_beat.active),
                                        16'(want.active));
                    if (out_beat.raw_value !== want.raw_value)
                        report_mismatch("raw_value", 16'(out_beat.raw_value),
                                        16'(want.raw_value));
                    if (out_beat.modifier_mask !== want.modifier_mask)
                        report_mismatch("modifier_mask", 16'(out_beat.modifier_mask),
                                        16'(want.modifier_mask));
                    if (out_beat.last !== want.last)
                        report_mismatch("last", 16'(out_beat.last), 16'(want.last));
                end
                events_seen++;
            end
            if (stall_left != 0) begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end else begin
                out_stall  <= 1'b0;
                stall_left <= draw_pause();
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_beat(input logic op, input logic [9:0] code,
                              input logic [1:0] val);
        t_in b;
        b.operation = op;
        b.key_code  = code;
        b.key_value = val;
        pending_beats = {pending_beats, b};
        beats_queued++;
    endtask

    task automatic queue_ticks(input int n);
        int k;
        for (k = 0; k < n; k++)
            queue_beat(OP_TICK, 10'($urandom_range(0, KEY_TOP)),
                       2'($urandom_range(0, 3)));
    endtask

    // Wait until every beat is taken and every result has come back
    task automatic wait_drained();
        @(posedge i_clk);
        while (beats_taken != beats_queued || regs_written != regs_queued ||
               awaited_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic program_timing(input int init, input int rep, input int start,
                                  input int cut, input int flr);
        t_reg_write w;
        w.index = CFG_INITIAL_DELAY; w.data = 16'(init);  pending_regs = {pending_regs, w};
        w.index = CFG_REPEAT_DELAY;  w.data = 16'(rep);   pending_regs = {pending_regs, w};
        w.index = CFG_ACCEL_START;   w.data = 16'(start); pending_regs = {pending_regs, w};
        w.index = CFG_ACCEL_STEP;    w.data = 16'(cut);   pending_regs = {pending_regs, w};
        w.index = CFG_ACCEL_FLOOR;   w.data = 16'(flr);   pending_regs = {pending_regs, w};
        regs_queued += 5;
        while (regs_written != regs_queued) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [9:0] random_modifier();
        case ($urandom_range(0, 7))
            0: return KEY_LSHIFT;
            1: return KEY_RSHIFT;
            2: return KEY_LCTRL;
            3: return KEY_RCTRL;
            4: return KEY_LALT;
            5: return KEY_RALT;
            6: return KEY_LMETA;
            default: return KEY_RMETA;
        endcase
    endfunction

    // Ordinary key, with backspace and delete favored
    function automatic logic [9:0] random_plain_key();
        logic [9:0] code;
        case ($urandom_range(0, 3))
            0: return CODE_BACKSPACE;
            1: return CODE_DELETE;
            default: begin
                code = 10'($urandom_range(0, KEY_TOP));
                while (mask_for_key(code) != 4'b0000)
                    code = 10'($urandom_range(0, KEY_TOP));
                return code;
            end
        endcase
    endfunction

    // Press, hold for a random number of ticks, release; plus some noise
    task automatic queue_typing(input int budget, input int tick_cap);
        int         made;
        int         n_ticks;
        int         k;
        logic [9:0] code;
        made = 0;
        while (made < budget) begin
            if ($urandom_range(0, 9) < 7) begin
                code = random_plain_key();
                queue_beat(OP_KEY, code, VAL_PRESS);
                n_ticks = $urandom_range(0, tick_cap);
                for (k = 0; k < n_ticks; k++) begin
                    // chords and stray key traffic while the key is held
                    if ($urandom_range(0, 19) == 0) begin
                        queue_beat(OP_KEY, random_modifier(), 2'($urandom_range(0, 3)));
                        made++;
                    end else if ($urandom_range(0, 29) == 0) begin
                        queue_beat(OP_KEY, 10'($urandom_range(0, KEY_TOP)),
                                   $urandom_range(0, 1) ? VAL_DEVICE_REPEAT : VAL_UNUSED);
                        made++;
                    end
                    queue_ticks(1);
                end
                if ($urandom_range(0, 4) != 0) queue_beat(OP_KEY, code, VAL_RELEASE);
                else queue_beat(OP_KEY, random_plain_key(), VAL_RELEASE);
                made += n_ticks + 2;
            end else begin
                // unshaped traffic
                for (k = $urandom_range(1, 4); k > 0; k--)
                    queue_beat(1'($urandom_range(0, 1)), 10'($urandom_range(0, KEY_TOP)),
                               2'($urandom_range(0, 3)));
                made += 2;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed beats under the reset timing
        queue_beat(OP_TICK, KEY_TOP, VAL_UNUSED);              // tick with nothing held
        queue_beat(OP_KEY, 10'd0, VAL_PRESS);
        queue_beat(OP_KEY, 10'd0, VAL_DEVICE_REPEAT);          // dropped
        queue_beat(OP_KEY, KEY_TOP, VAL_UNUSED);               // dropped
        queue_beat(OP_KEY, 10'd511, VAL_RELEASE);              // other key, stays armed
        queue_beat(OP_TICK, 10'd0, VAL_RELEASE);
        queue_beat(OP_KEY, KEY_LSHIFT, VAL_PRESS);
        queue_beat(OP_KEY, KEY_RCTRL, VAL_PRESS);
        queue_beat(OP_KEY, KEY_LALT, VAL_UNUSED);              // value three counts as down
        queue_beat(OP_KEY, KEY_RMETA, VAL_DEVICE_REPEAT);
        queue_beat(OP_KEY, KEY_RSHIFT, VAL_RELEASE);
        queue_beat(OP_KEY, KEY_LCTRL, VAL_RELEASE);
        queue_beat(OP_KEY, KEY_RALT, VAL_RELEASE);
        queue_beat(OP_KEY, KEY_LMETA, VAL_RELEASE);
        queue_beat(OP_KEY, 10'd0, VAL_RELEASE);                // disarm
        queue_beat(OP_TICK, 10'd0, VAL_PRESS);
        queue_beat(OP_KEY, KEY_TOP, VAL_PRESS);
        queue_beat(OP_KEY, KEY_TOP, VAL_RELEASE);
        // delete held through the default initial delay and three repeats
        queue_beat(OP_KEY, CODE_DELETE, VAL_PRESS);
        queue_ticks(RST_INITIAL_DELAY + 45 + 40);
        queue_beat(OP_KEY, CODE_DELETE, VAL_RELEASE);
        wait_drained();

        // short delays with visible acceleration; pause half way for all results
        program_timing(3, 2, 9, 1, 1);
        queue_typing(50, 40);
        wait_drained();
        queue_typing(50, 40);
        wait_drained();

        // lowest values everywhere: a repeat on every tick
        program_timing(1, 1, 1, 0, 1);
        queue_typing(100, 30);
        wait_drained();

        // large accel base with the widest step
        program_timing(7, 4, 65535, 255, 3);
        queue_typing(100, 60);
        wait_drained();

        // highest values: no repeat ever fires
        program_timing(65535, 65535, 65535, 255, 65535);
        queue_typing(100, 8);
        wait_drained();

        program_timing(4, 6, 30, 2, 4);
        queue_typing(100, 60);
        wait_drained();

        program_timing($urandom_range(1, 12), $urandom_range(1, 8),
                       $urandom_range(1, 60), $urandom_range(0, 255),
                       $urandom_range(1, 20));
        queue_typing(100, 50);
        wait_drained();

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Hard stop if results never arrive
    initial begin
        repeat (RUN_LIMIT) @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
